// ----- src/mqst_pkg.sv -----
// Shared types and constants for the multi-queue slot table.
// Used by the controller, the datapath and the top level.
package mqst_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 64;
  localparam int unsigned QUEUE_COUNT_DEF = 4;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_QUERY  = 3'd2;
  localparam logic [2:0] MODE_NEXT   = 3'd3;
  localparam logic [2:0] MODE_SETPOS = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         queue_id;
    logic               any_queue;
    logic [5:0]         slot;
    logic               slot_active;
    logic               from_head;
    logic [15:0]        user_word;
    logic signed [7:0]  new_position;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic               is_member;
    logic signed [7:0]  position;
    logic [15:0]        stored_word;
    logic [5:0]         next_slot;
    logic               next_valid;
    logic [6:0]         queue_count;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_EVAL,
    OP_ADD_LINK,
    OP_ADD_FIN,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_UNLINK,
    OP_REN_STEP,
    OP_SETPOS,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic add_go;
    logic rem_go;
    logic set_go;
    logic found;
    logic ren_more;
  } dp_status_t;

endpackage

// ----- src/mqst_datapath.sv -----
// Datapath: slot memories, queue head/tail/length registers, walk pointers.
// Depends on mqst_pkg; driven by mqst_ctrl commands.
module mqst_datapath import mqst_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  item_t      item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output result_t    result_o
);

  localparam int unsigned SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LinkW  = SlotW + 1;
  localparam int unsigned OwnW   = $clog2(QUEUE_COUNT + 1);
  localparam int unsigned QIdxW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [LinkW-1:0] NoneMark = LinkW'(SLOT_COUNT);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOT_COUNT - 1);

  logic [3:0]             fifo_q;
  item_t                  item_q;
  result_t                res_q;
  logic [1:0]             cq_q, hq_q;
  logic [LinkW-1:0]       cur_q, prev_q, nx_q;
  logic [SlotW-1:0]       clr_q;

  logic [LinkW-1:0]       head_q  [QUEUE_COUNT];
  logic [LinkW-1:0]       tail_q  [QUEUE_COUNT];
  logic [6:0]             len_q   [QUEUE_COUNT];

  logic [OwnW-1:0]        own_mem  [SLOT_COUNT];
  logic [LinkW-1:0]       link_mem [SLOT_COUNT];
  logic [7:0]             pos_mem  [SLOT_COUNT];
  logic [15:0]            word_mem [SLOT_COUNT];
  logic [OwnW-1:0]        own_rd_q;
  logic [LinkW-1:0]       link_rd_q;
  logic [7:0]             pos_rd_q;
  logic [15:0]            word_rd_q;

  logic [SlotW-1:0]       raddr, s_idx;
  logic [LinkW-1:0]       s_link;
  logic [QIdxW-1:0]       q_idx, hq_idx;
  logic                   act, q_ok, inq;
  logic [OwnW-1:0]        own_s;
  logic [7:0]             add_pos;
  logic                   link_we, pos_we, own_we;
  logic [SlotW-1:0]       link_wa, pos_wa, own_wa;
  logic [LinkW-1:0]       link_wd;
  logic [7:0]             pos_wd;
  logic [OwnW-1:0]        own_wd;
  result_t                res_d;
  logic [1:0]             cq_d;

  assign s_idx  = SlotW'(item_q.slot);
  assign s_link = {1'b0, s_idx};
  assign q_idx  = QIdxW'(item_q.queue_id);
  assign hq_idx = QIdxW'(hq_q);
  assign act    = item_q.slot_active && (32'(item_q.slot) < SLOT_COUNT);
  assign q_ok   = 32'(item_q.queue_id) < QUEUE_COUNT;
  assign own_s  = own_rd_q;
  assign inq    = q_ok && (own_s == OwnW'(item_q.queue_id) + OwnW'(1));
  assign add_pos = fifo_q[item_q.queue_id] ? {1'b0, len_q[q_idx] + 7'd1} : 8'hFF;

  assign status_o.clr_last = (clr_q == LastSlot);
  assign status_o.add_go   = (item_q.mode == MODE_ADD) && act && q_ok && (own_s == '0);
  assign status_o.rem_go   = (item_q.mode == MODE_REMOVE) && act && (own_s != '0) &&
                             (item_q.any_queue || inq);
  assign status_o.set_go   = (item_q.mode == MODE_SETPOS) && act && inq;
  assign status_o.found    = (cur_q == s_link);
  assign status_o.ren_more = fifo_q[hq_q] && (nx_q < NoneMark);

  // shared read address for the slot memories
  always_comb begin
    unique case (cmd_i.op)
      OP_LATCH:     raddr = SlotW'(item_i.slot);
      OP_WALK_INIT: raddr = SlotW'(head_q[hq_idx]);
      OP_WALK_STEP,
      OP_UNLINK,
      OP_REN_STEP:  raddr = SlotW'(link_rd_q);
      default:      raddr = s_idx;
    endcase
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = s_idx;
    link_wd = NoneMark;
    pos_we  = 1'b0;
    pos_wa  = s_idx;
    pos_wd  = add_pos;
    own_we  = 1'b0;
    own_wa  = s_idx;
    own_wd  = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        own_we = 1'b1;
        own_wa = clr_q;
      end
      OP_ADD_LINK: begin
        link_we = tail_q[q_idx] < NoneMark;
        link_wa = SlotW'(tail_q[q_idx]);
        link_wd = s_link;
      end
      OP_ADD_FIN: begin
        link_we = 1'b1;
        pos_we  = 1'b1;
        own_we  = 1'b1;
        own_wd  = OwnW'(item_q.queue_id) + OwnW'(1);
      end
      OP_UNLINK: begin
        link_we = prev_q != NoneMark;
        link_wa = SlotW'(prev_q);
        link_wd = link_rd_q;
        own_we  = 1'b1;
      end
      OP_REN_STEP: begin
        pos_we = 1'b1;
        pos_wa = SlotW'(nx_q);
        pos_wd = pos_rd_q - 8'd1;
      end
      OP_SETPOS: begin
        pos_we = 1'b1;
        pos_wd = item_q.new_position;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (cmd_i.op == OP_ADD_FIN) begin
      word_mem[s_idx] <= item_q.user_word;
    end
    own_rd_q  <= own_mem[raddr];
    link_rd_q <= link_mem[raddr];
    pos_rd_q  <= pos_mem[raddr];
    word_rd_q <= word_mem[raddr];
  end

  // result fields other than queue_count, taken before any update of this item
  always_comb begin
    res_d = '0;
    cq_d  = item_q.queue_id;
    case (item_q.mode)
      MODE_ADD: begin
        res_d.ok = status_o.add_go;
        if (status_o.add_go) begin
          res_d.is_member   = 1'b1;
          res_d.position    = add_pos;
          res_d.stored_word = item_q.user_word;
        end else if (act && inq) begin
          res_d.is_member   = 1'b1;
          res_d.position    = pos_rd_q;
          res_d.stored_word = word_rd_q;
        end
      end
      MODE_REMOVE: begin
        res_d.ok = status_o.rem_go;
        if (status_o.rem_go) begin
          cq_d = 2'(own_s - OwnW'(1));
        end
      end
      MODE_QUERY: begin
        if (act && (item_q.any_queue ? (own_s != '0) : inq)) begin
          res_d.ok          = 1'b1;
          res_d.is_member   = 1'b1;
          res_d.position    = pos_rd_q;
          res_d.stored_word = word_rd_q;
          if (item_q.any_queue) begin
            cq_d = 2'(own_s - OwnW'(1));
          end
        end
      end
      MODE_NEXT: begin
        if (item_q.from_head) begin
          res_d.ok        = 1'b1;
          res_d.is_member = act && inq;
          if (q_ok && (head_q[q_idx] < NoneMark)) begin
            res_d.next_slot  = 6'(head_q[q_idx]);
            res_d.next_valid = 1'b1;
          end
        end else if (act && inq) begin
          res_d.ok        = 1'b1;
          res_d.is_member = 1'b1;
          if (link_rd_q < NoneMark) begin
            res_d.next_slot  = 6'(link_rd_q);
            res_d.next_valid = 1'b1;
          end
        end
      end
      MODE_SETPOS: begin
        if (status_o.set_go) begin
          res_d.ok          = 1'b1;
          res_d.is_member   = 1'b1;
          res_d.position    = item_q.new_position;
          res_d.stored_word = word_rd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: item_q <= item_i;
      OP_EVAL: begin
        res_q <= res_d;
        cq_q  <= cq_d;
        hq_q  <= 2'(own_s - OwnW'(1));
      end
      OP_WALK_INIT: begin
        cur_q  <= head_q[hq_idx];
        prev_q <= NoneMark;
      end
      OP_WALK_STEP: begin
        prev_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      OP_UNLINK,
      OP_REN_STEP: nx_q <= link_rd_q;
      OP_RESULT: begin
        res_q.queue_count <= (32'(cq_q) < QUEUE_COUNT) ? len_q[QIdxW'(cq_q)] : 7'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_q <= '0;
      clr_q  <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_q[i] <= NoneMark;
        tail_q[i] <= NoneMark;
        len_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        fifo_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + SlotW'(1);
      end
      if (cmd_i.op == OP_ADD_FIN) begin
        tail_q[q_idx] <= s_link;
        if (head_q[q_idx] >= NoneMark) begin
          head_q[q_idx] <= s_link;
        end
        len_q[q_idx] <= len_q[q_idx] + 7'd1;
      end
      if (cmd_i.op == OP_UNLINK) begin
        if (prev_q == NoneMark) begin
          head_q[hq_idx] <= link_rd_q;
        end
        if (tail_q[hq_idx] == s_link) begin
          tail_q[hq_idx] <= prev_q;
        end
        len_q[hq_idx] <= len_q[hq_idx] - 7'd1;
      end
    end
  end

  assign result_o = res_q;

endmodule

// ----- src/mqst_ctrl.sv -----
// Controller state machine: sequences each word through the datapath.
// Depends on mqst_pkg.
module mqst_ctrl import mqst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_ADD_LINK, S_ADD_FIN, S_WALK_INIT, S_WALK, S_REN, S_SETPOS,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      // owner table sweep after reset, one slot per cycle
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        if (status_i.add_go) begin
          state_d = S_ADD_LINK;
        end else if (status_i.rem_go) begin
          state_d = S_WALK_INIT;
        end else if (status_i.set_go) begin
          state_d = S_SETPOS;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_ADD_LINK: begin
        cmd_o.op = OP_ADD_LINK;
        state_d  = S_ADD_FIN;
      end
      S_ADD_FIN: begin
        cmd_o.op = OP_ADD_FIN;
        state_d  = S_RESULT;
      end
      S_WALK_INIT: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (status_i.found) begin
          cmd_o.op = OP_UNLINK;
          state_d  = S_REN;
        end else begin
          cmd_o.op = OP_WALK_STEP;
        end
      end
      S_REN: begin
        if (status_i.ren_more) begin
          cmd_o.op = OP_REN_STEP;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SETPOS: begin
        cmd_o.op = OP_SETPOS;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.op = OP_RESULT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RESULT);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EVAL))
    else $error("accepted word did not reach evaluation");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

endmodule

// ----- src/multi_queue_slot_table_top.sv -----
// Top level of the multi-queue slot table: controller plus datapath.
// Depends on mqst_pkg, mqst_ctrl and mqst_datapath.
//
// A word is taken when start is high and busy is low; its result appears on
// result_o for exactly one cycle with done_o high, and must be taken then.
// Query, next and unused modes go from evaluation straight to the result
// state; set position adds a position write, add a link and a finish step.
// Remove walks its queue from the head (one linked-list read per cycle),
// unlinks the slot and, in a FIFO queue, renumbers the entries behind it
// (one position update per cycle). Only one word is in flight at a time;
// busy drops in the strobe cycle, so a new word may be started then. After
// reset busy stays high while the slot ownership table is cleared.
module multi_queue_slot_table_top import mqst_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  output logic       done_o,
  output result_t    result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mqst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  mqst_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

// ----- verif/tb_multi_queue_slot_table_top.sv -----
// Self-checking testbench for multi_queue_slot_table_top.
// Depends on mqst_pkg and the RTL; keeps its own copy of the queue table to predict each word.
module tb_multi_queue_slot_table_top import mqst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int NQUEUE = QUEUE_COUNT_DEF;
  localparam logic [6:0] NO_SLOT = 7'(NSLOT);
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  item_t item_i = '0;
  logic done_o;
  result_t result_o;

  multi_queue_slot_table_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the slot table
  logic [3:0]  fifo_bits;
  logic [2:0]  owner[NSLOT];
  logic [6:0]  link[NSLOT];
  logic [7:0]  spos[NSLOT];
  logic [15:0] sword[NSLOT];
  logic [6:0]  qhead[NQUEUE];
  logic [6:0]  qtail[NQUEUE];
  logic [6:0]  qlen[NQUEUE];

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic result_t table_apply(item_t it);
    result_t r;
    int q, s, t, prev, cur, nx, hq, cq;
    bit act, hit;
    r = '0;
    q = it.queue_id;
    s = it.slot;
    act = it.slot_active;
    cq = q;
    case (it.mode)
      MODE_ADD: begin
        if (act && owner[s] == 0) begin
          t = qtail[q];
          owner[s] = 3'(q + 1);
          link[s] = NO_SLOT;
          if (t < NSLOT) link[t] = 7'(s);
          qtail[q] = 7'(s);
          if (qhead[q] >= NSLOT) qhead[q] = 7'(s);
          qlen[q] = qlen[q] + 7'd1;
          spos[s] = fifo_bits[q] ? 8'(qlen[q]) : 8'hFF;
          sword[s] = it.user_word;
          r.ok = 1'b1;
        end
        if (act && owner[s] == q + 1) begin
          r.is_member = 1'b1;
          r.position = spos[s];
          r.stored_word = sword[s];
        end
      end
      MODE_REMOVE: begin
        if (act && owner[s] != 0 && (it.any_queue || owner[s] == q + 1)) begin
          hq = owner[s] - 1;
          prev = NSLOT;
          cur = qhead[hq];
          for (int n = 0; n < NSLOT && cur < NSLOT; n++) begin
            if (cur == s) begin
              nx = link[s];
              if (prev == NSLOT) qhead[hq] = 7'(nx);
              else link[prev] = 7'(nx);
              if (qtail[hq] == s) qtail[hq] = 7'(prev);
              qlen[hq] = qlen[hq] - 7'd1;
              // FIFO queues renumber everyone behind the removed slot
              if (fifo_bits[hq]) begin
                for (int k = 0; k < NSLOT && nx < NSLOT; k++) begin
                  spos[nx] = spos[nx] - 8'd1;
                  nx = link[nx];
                end
              end
              break;
            end
            prev = cur;
            cur = link[cur];
          end
          owner[s] = '0;
          cq = hq;
          r.ok = 1'b1;
        end
        if (act && owner[s] == q + 1) r.is_member = 1'b1;
      end
      MODE_QUERY: begin
        if (act) begin
          hit = it.any_queue ? owner[s] != 0 : owner[s] == q + 1;
          if (hit) begin
            r.ok = 1'b1;
            r.is_member = 1'b1;
            r.position = spos[s];
            r.stored_word = sword[s];
            if (it.any_queue) cq = owner[s] - 1;
          end
        end
      end
      MODE_NEXT: begin
        if (it.from_head) begin
          r.ok = 1'b1;
          if (qhead[q] < NSLOT) begin
            r.next_slot = qhead[q][5:0];
            r.next_valid = 1'b1;
          end
          if (act && owner[s] == q + 1) r.is_member = 1'b1;
        end else if (act && owner[s] == q + 1) begin
          r.ok = 1'b1;
          r.is_member = 1'b1;
          if (link[s] < NSLOT) begin
            r.next_slot = link[s][5:0];
            r.next_valid = 1'b1;
          end
        end
      end
      MODE_SETPOS: begin
        if (act && owner[s] == q + 1) begin
          spos[s] = it.new_position;
          r.ok = 1'b1;
          r.is_member = 1'b1;
          r.position = spos[s];
          r.stored_word = sword[s];
        end
      end
      default: ;
    endcase
    r.queue_count = qlen[cq];
    return r;
  endfunction

  // Present one word, hold it until taken, then log its expected result.
  // start is left high; the next call or the caller lowers it when a gap follows.
  task automatic send_word(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(table_apply(it));
  endtask

  task automatic drain_and_write_mask(logic [3:0] mask);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fifo_bits = mask;
  endtask

  function automatic item_t make_word(logic [2:0] mode, int q, int s, bit act,
                                      bit anyq, bit fromh, logic [15:0] w,
                                      logic [7:0] np);
    item_t it;
    it.mode = mode;
    it.queue_id = 2'(q);
    it.any_queue = anyq;
    it.slot = 6'(s);
    it.slot_active = act;
    it.from_head = fromh;
    it.user_word = w;
    it.new_position = np;
    return it;
  endfunction

  // Queued slots 55% of the time so that remove, query and walk hit something.
  function automatic int pick_slot();
    int base;
    base = $urandom_range(NSLOT - 1);
    if ($urandom_range(99) < 55) begin
      for (int i = 0; i < NSLOT; i++)
        if (owner[(base + i) % NSLOT] != 0) return (base + i) % NSLOT;
    end
    return base;
  endfunction

  task automatic test_directed_plain();
    send_word(make_word(MODE_QUERY, 0, 0, 1, 0, 0, 16'h0, 8'h0));
    send_word(make_word(MODE_NEXT, 3, 0, 0, 0, 1, 16'h0, 8'h0));
    send_word(make_word(MODE_ADD, 0, 0, 1, 0, 0, 16'hFFFF, 8'h0));
    send_word(make_word(MODE_ADD, 0, 0, 1, 0, 0, 16'h1234, 8'h0)); // already queued
    send_word(make_word(MODE_ADD, 1, 5, 0, 0, 0, 16'h5555, 8'h0)); // inactive slot
    send_word(make_word(MODE_ADD, 3, 63, 1, 1, 1, 16'h0000, 8'hFF));
    send_word(make_word(MODE_ADD, 0, 63, 1, 0, 0, 16'hAAAA, 8'h0)); // queued elsewhere
    send_word(make_word(MODE_ADD, 0, 17, 1, 0, 0, 16'h8001, 8'h0));
    send_word(make_word(MODE_QUERY, 2, 63, 1, 1, 0, 16'h0, 8'h0));
    send_word(make_word(MODE_NEXT, 0, 0, 1, 0, 0, 16'h0, 8'h0));
    send_word(make_word(MODE_NEXT, 0, 17, 1, 0, 0, 16'h0, 8'h0)); // end of queue
    send_word(make_word(MODE_SETPOS, 0, 17, 1, 0, 0, 16'h0, 8'h80));
    send_word(make_word(MODE_SETPOS, 0, 17, 1, 0, 0, 16'h0, 8'h7F));
    send_word(make_word(MODE_SETPOS, 1, 17, 1, 0, 0, 16'h0, 8'h40)); // wrong queue
    send_word(make_word(MODE_REMOVE, 1, 0, 1, 0, 0, 16'h0, 8'h0)); // wrong queue
    send_word(make_word(MODE_REMOVE, 2, 0, 1, 1, 0, 16'h0, 8'h0));
    send_word(make_word(3'd5, 3, 63, 1, 1, 1, 16'hFFFF, 8'hFF));
    send_word(make_word(3'd6, 0, 0, 0, 0, 0, 16'h0, 8'h0));
    send_word(make_word(3'd7, 3, 0, 1, 0, 0, 16'h0, 8'h0));
  endtask

  task automatic test_directed_fifo();
    drain_and_write_mask(4'hF);
    for (int s = 10; s < 14; s++) send_word(make_word(MODE_ADD, 2, s, 1, 0, 0, 16'(s), 8'h0));
    send_word(make_word(MODE_REMOVE, 2, 11, 1, 0, 0, 16'h0, 8'h0)); // middle, renumbers
    send_word(make_word(MODE_QUERY, 2, 13, 1, 0, 0, 16'h0, 8'h0));
    send_word(make_word(MODE_REMOVE, 0, 13, 1, 1, 0, 16'h0, 8'h0)); // tail
    send_word(make_word(MODE_QUERY, 1, 12, 1, 1, 0, 16'h0, 8'h0));
  endtask

  task automatic test_random(logic [3:0] mask, int pct, int count);
    int m, s;
    item_t it;
    drain_and_write_mask(mask);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(99);
      s = pick_slot();
      it = make_word(MODE_ADD, $urandom_range(NQUEUE - 1), s, $urandom_range(99) < 92,
                     $urandom_range(1), $urandom_range(1), 16'($urandom),
                     8'($urandom));
      if (m < 35) it.mode = MODE_ADD;
      else if (m < 57) it.mode = MODE_REMOVE;
      else if (m < 72) it.mode = MODE_QUERY;
      else if (m < 87) it.mode = MODE_NEXT;
      else if (m < 96) it.mode = MODE_SETPOS;
      else it.mode = 3'($urandom_range(7, 5));
      // steer to the owning queue most of the time
      if (owner[s] != 0 && $urandom_range(99) < 70) it.queue_id = 2'(owner[s] - 1);
      send_word(it);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout", $realtime);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: exp none act %h", $realtime, result_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.ok !== result_o.ok || want.is_member !== result_o.is_member
            || want.position !== result_o.position
            || want.stored_word !== result_o.stored_word
            || want.next_slot !== result_o.next_slot
            || want.next_valid !== result_o.next_valid
            || want.queue_count !== result_o.queue_count) begin
          $display("%0t mismatch: exp ok=%b mem=%b pos=%0d word=%h next=%0d nv=%b cnt=%0d",
                   $realtime, want.ok, want.is_member, want.position, want.stored_word,
                   want.next_slot, want.next_valid, want.queue_count);
          $display("%0t          act ok=%b mem=%b pos=%0d word=%h next=%0d nv=%b cnt=%0d",
                   $realtime, result_o.ok, result_o.is_member, result_o.position,
                   result_o.stored_word, result_o.next_slot, result_o.next_valid,
                   result_o.queue_count);
          errors++;
        end
      end
    end
  end

  initial begin
    fifo_bits = '0;
    for (int i = 0; i < NSLOT; i++) begin
      owner[i] = '0; link[i] = '0; spos[i] = '0; sword[i] = '0;
    end
    for (int q = 0; q < NQUEUE; q++) begin
      qhead[q] = NO_SLOT; qtail[q] = NO_SLOT; qlen[q] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_plain();
    test_directed_fifo();
    test_random(4'h0, 18, 210);
    test_random(4'hF, 18, 210);
    test_random(4'h5, 75, 200);
    test_random(4'hA, 75, 200);
    test_random(4'($urandom), 0, 210);
    test_random(4'($urandom), 0, 200);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mqst_pkg.sv
src/mqst_datapath.sv
src/mqst_ctrl.sv
src/multi_queue_slot_table_top.sv
verif/tb_multi_queue_slot_table_top.sv
